@@ rtl/core/bba_pkg.sv @@
// Shared types and constants for the buddy block allocator.
// Depends on nothing; imported by bba_seq, the top level and the testbench.
package bba_pkg;

  // default geometry
  localparam int unsigned HEAP_BYTES_DEF   = 65536;
  localparam int unsigned MIN_ORDER_DEF    = 5;
  localparam int unsigned MAX_ORDER_DEF    = 15;
  localparam int unsigned HEADER_BYTES_DEF = 24;

  // fixed field widths
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned STATUS_W = 2;

  // result codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOOBIG  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

  // action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_TAKE,
    S_A_SPLIT,
    S_F_RD,
    S_F_CHK,
    S_F_BRD,
    S_F_BCHK,
    S_F_SET,
    S_DONE
  } bba_state_t;

  // request from port side to sequencer
  typedef struct packed {
    logic               start;
    logic               action;
    logic [FIELD_W-1:0] request_bytes;
    logic [FIELD_W-1:0] address;
  } bba_req_t;

  // sequencer status back to port side
  typedef struct packed {
    logic                ready;
    logic                valid;
    logic [STATUS_W-1:0] status;
  } bba_rsp_t;

endpackage

@@ rtl/core/bba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bba_seq.sv @@
// Allocator sequencer: free tree, allocation table and one shared node-index unit.
// Depends on bba_pkg and bba_ram.
module bba_seq #(
  parameter int unsigned HEAP_BYTES   = bba_pkg::HEAP_BYTES_DEF,
  parameter int unsigned MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
  parameter int unsigned MAX_ORDER    = bba_pkg::MAX_ORDER_DEF,
  parameter int unsigned HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bba_pkg::bba_req_t req,
  input  logic              rsp_take,
  output bba_pkg::bba_rsp_t rsp
);
  import bba_pkg::*;

  localparam int unsigned UNITS  = HEAP_BYTES >> MIN_ORDER;
  localparam int unsigned NODES  = 2 * UNITS;
  localparam int unsigned ROOTS  = HEAP_BYTES >> MAX_ORDER;
  localparam int unsigned USABLE = ROOTS << MAX_ORDER;
  localparam int unsigned UW     = $clog2(UNITS);
  localparam int unsigned NW     = $clog2(NODES);
  localparam int unsigned OW     = $clog2(MAX_ORDER + 2);
  localparam int unsigned LW     = $clog2(MAX_ORDER - MIN_ORDER + 1);
  localparam int unsigned AB     = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned CW0    = (AB > FIELD_W + 1) ? AB : FIELD_W + 1;
  localparam int unsigned CW     = (CW0 > MAX_ORDER + 2) ? CW0 : MAX_ORDER + 2;
  localparam logic [CW-1:0] LIMIT  = CW'((64'd1 << MAX_ORDER) - HEADER_BYTES);
  localparam logic [CW-1:0] HDR    = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] USE_B  = CW'(USABLE);
  localparam logic [CW-1:0] ALIGN  = CW'((64'd1 << MIN_ORDER) - 1);
  localparam logic [OW-1:0] OMIN   = OW'(MIN_ORDER);
  localparam logic [OW-1:0] OMAX   = OW'(MAX_ORDER);

  // first free-bit index of each order (constant table)
  function automatic logic [NW-1:0] node_base(input logic [OW-1:0] ord);
    logic [NW:0] base;
    base = '0;
    for (int o = MIN_ORDER; o <= MAX_ORDER; o++) begin
      if (OW'(o) < ord) base = base + (NW+1)'(HEAP_BYTES >> o);
    end
    return base[NW-1:0];
  endfunction

  localparam logic [NW-1:0] ROOT_LO = node_base(OMAX);
  localparam logic [NW:0]   ROOT_HI = {1'b0, ROOT_LO} + (NW+1)'(ROOTS);

  bba_state_t state, state_next;
  logic [OW-1:0]  k, k_next, ord, ord_next;
  logic [UW:0]    idx, idx_next;
  logic [CW-1:0]  head, head_next;
  logic [STATUS_W-1:0] status, status_next;
  logic [NW-1:0]  clr, clr_next;

  // shared node-index unit
  logic [OW-1:0] nk;
  logic [CW-1:0] na, a_shift;
  logic [NW-1:0] node;

  // memories
  logic          t_we, t_wd, t_rd;
  logic [NW-1:0] t_wa, t_ra;
  logic          v_we, v_wd, v_rd;
  logic [UW-1:0] v_wa;
  logic          o_we;
  logic [LW-1:0] o_rd;

  logic [CW-1:0]   data_c, head_c, need;
  logic [OW-1:0]   ord_c, ord_f;
  logic [UW:0]     count;
  logic [UW-1:0]   unit;
  logic [OW:0]     ord_sum;

  assign a_shift = na >> nk;
  assign node    = node_base(nk) + a_shift[NW-1:0];
  assign unit    = head[MIN_ORDER +: UW];
  assign count   = (UW+1)'(ROOTS) << (OMAX - k);
  assign data_c  = CW'(req.address);
  assign head_c  = data_c - HDR;
  assign need    = CW'(req.request_bytes) + HDR;
  assign ord_sum = {1'b0, OW'(o_rd)} + {1'b0, OMIN};
  assign ord_f   = (ord_sum > {1'b0, OMAX}) ? OMAX : ord_sum[OW-1:0];

  // smallest adequate order
  always_comb begin
    ord_c = OMAX;
    for (int o = MAX_ORDER - 1; o >= MIN_ORDER; o--) begin
      if ((CW'(1) << o) >= need) ord_c = OW'(o);
    end
  end

  bba_ram #(.WIDTH(1), .DEPTH(NODES)) u_tree (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
  );
  bba_ram #(.WIDTH(1), .DEPTH(UNITS)) u_valid (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(unit), .rdata(v_rd)
  );
  bba_ram #(.WIDTH(LW), .DEPTH(UNITS)) u_order (
    .clk(clk), .we(o_we), .waddr(unit), .wdata(LW'(ord - OMIN)), .raddr(unit),
    .rdata(o_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
    k      <= k_next;
    ord    <= ord_next;
    idx    <= idx_next;
    head   <= head_next;
    status <= status_next;
  end

  always_comb begin
    state_next  = state;
    clr_next    = clr;
    k_next      = k;
    ord_next    = ord;
    idx_next    = idx;
    head_next   = head;
    status_next = status;
    nk   = k;
    na   = head;
    t_we = 1'b0;
    t_wd = 1'b0;
    t_wa = node;
    t_ra = node;
    v_we = 1'b0;
    v_wd = 1'b0;
    v_wa = unit;
    o_we = 1'b0;
    rsp.ready  = 1'b0;
    rsp.valid  = 1'b0;
    rsp.status = status;

    case (state)
      // after reset: only roots free, no block allocated
      S_CLEAR: begin
        t_we = 1'b1;
        t_wa = clr;
        t_wd = (clr >= ROOT_LO) && ({1'b0, clr} < ROOT_HI);
        v_we = ({1'b0, clr} < (NW+1)'(UNITS));
        v_wa = clr[UW-1:0];
        clr_next = clr + NW'(1);
        if (clr == NW'(NODES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        rsp.ready = 1'b1;
        if (req.start) begin
          if (req.action == ACT_ALLOC) begin
            if (CW'(req.request_bytes) > LIMIT) begin
              status_next = ST_TOOBIG;
              state_next  = S_DONE;
            end else begin
              ord_next   = ord_c;
              k_next     = ord_c;
              idx_next   = '0;
              state_next = S_A_RD;
            end
          end else begin
            head_next = head_c;
            if (data_c < HDR || (head_c & ALIGN) != '0 || head_c >= USE_B) begin
              status_next = ST_UNKNOWN;
              state_next  = S_DONE;
            end else begin
              state_next = S_F_RD;
            end
          end
        end
      end
      // scan free bits of order k in address order
      S_A_RD: begin
        na = CW'(idx) << k;
        state_next = S_A_CHK;
      end
      S_A_CHK: begin
        if (t_rd) begin
          head_next  = CW'(idx) << k;
          state_next = S_A_TAKE;
        end else if (idx == count - (UW+1)'(1)) begin
          if (k == OMAX) begin
            status_next = ST_NOMEM;
            state_next  = S_DONE;
          end else begin
            k_next     = k + OW'(1);
            idx_next   = '0;
            state_next = S_A_RD;
          end
        end else begin
          idx_next   = idx + (UW+1)'(1);
          state_next = S_A_RD;
        end
      end
      S_A_TAKE: begin
        t_we = 1'b1;
        state_next = S_A_SPLIT;
      end
      // free upper halves down to the wanted order
      S_A_SPLIT: begin
        nk = k - OW'(1);
        na = head | (CW'(1) << nk);
        if (k > ord) begin
          t_we   = 1'b1;
          t_wd   = 1'b1;
          k_next = k - OW'(1);
        end else begin
          v_we = 1'b1;
          v_wd = 1'b1;
          o_we = 1'b1;
          status_next = ST_OK;
          state_next  = S_DONE;
        end
      end
      S_F_RD: begin
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        if (!v_rd) begin
          status_next = ST_UNKNOWN;
          state_next  = S_DONE;
        end else begin
          v_we = 1'b1;
          ord_next   = ord_f;
          state_next = S_F_BRD;
        end
      end
      // coalesce with free buddies
      S_F_BRD: begin
        nk = ord;
        na = head ^ (CW'(1) << ord);
        state_next = (ord < OMAX) ? S_F_BCHK : S_F_SET;
      end
      S_F_BCHK: begin
        nk = ord;
        na = head ^ (CW'(1) << ord);
        if (t_rd) begin
          t_we = 1'b1;
          head_next  = head & ~(CW'(1) << ord);
          ord_next   = ord + OW'(1);
          state_next = S_F_BRD;
        end else begin
          state_next = S_F_SET;
        end
      end
      S_F_SET: begin
        nk   = ord;
        t_we = 1'b1;
        t_wd = 1'b1;
        status_next = ST_OK;
        state_next  = S_DONE;
      end
      S_DONE: begin
        rsp.valid = 1'b1;
        if (rsp_take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/buddy_block_allocator.sv @@
// Top level of the buddy block allocator: stream ports and result register.
// Depends on bba_pkg, bba_seq (and through it bba_ram).
//
// channel  dir  tdata                                   tuser
// s_*      in   [15:0] request_bytes, [31:16] address   [0] action
// m_*      out  [1:0] status, [7:2] zero                -
//
// Allocate: scans free bits order by order from the smallest adequate order,
// then splits down to the wanted order; the scan can run over every order.
// Free: checks the block, then merges with free buddies until a buddy is not
// free or the top order is reached.
// After reset a clearing pass runs with s_tready low. One item at a time; a
// waiting result does not block the next item from being taken, only its
// completion.
module buddy_block_allocator #(
  parameter int unsigned HEAP_BYTES   = bba_pkg::HEAP_BYTES_DEF,
  parameter int unsigned MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
  parameter int unsigned MAX_ORDER    = bba_pkg::MAX_ORDER_DEF,
  parameter int unsigned HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_bytes, address
  input  logic [0:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // status, zero fill
);
  import bba_pkg::*;

  bba_req_t req;
  bba_rsp_t rsp;
  logic     rsp_take;
  logic [STATUS_W-1:0] status_q;

  assign s_tready          = rsp.ready;
  assign req.start         = s_tvalid && rsp.ready;
  assign req.action        = s_tuser[0];
  assign req.request_bytes = s_tdata[FIELD_W-1:0];
  assign req.address       = s_tdata[2*FIELD_W-1:FIELD_W];

  // result register takes a result when empty or being drained
  assign rsp_take = rsp.valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rsp_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (rsp_take) status_q <= rsp.status;
  end

  assign m_tdata = {{(8-STATUS_W){1'b0}}, status_q};

  bba_seq #(
    .HEAP_BYTES(HEAP_BYTES), .MIN_ORDER(MIN_ORDER),
    .MAX_ORDER(MAX_ORDER), .HEADER_BYTES(HEADER_BYTES)
  ) u_seq (
    .clk(clk), .rst(rst), .req(req), .rsp_take(rsp_take), .rsp(rsp)
  );

endmodule

@@ rtl/core/bba_checker.sv @@
// Port-level checks for the buddy block allocator, bound to the top level.
// Depends on buddy_block_allocator.
module bba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  // clearing pass blocks input right after reset
  a_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready during clearing pass");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while busy");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // fill bits stay zero
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:2] == 6'd0))
    else $error("result fill bits set");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ tb/testbench.sv @@
// Testbench for buddy_block_allocator: mixed allocate/free traffic checked
// against an in-bench buddy model. Depends on bba_pkg and the RTL top only.
`timescale 1ns / 100ps

module testbench;
  import bba_pkg::*;

  localparam int MINO = 5;
  localparam int MAXO = 15;
  localparam int HDR = 24;
  localparam int HEAP = 65536;
  localparam int UNIT_CNT = HEAP >> MINO;

  typedef struct {
    logic                action;
    logic [15:0]         req;
    logic [15:0]         addr;
    logic [STATUS_W-1:0] status;
  } heap_op_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [31:0] s_tdata;   // [15:0] request_bytes, [31:16] address
  logic [0:0] s_tuser;    // [0] action
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;    // [1:0] status, [7:2] zero

  // shadow heap state
  bit free_map [MINO:MAXO][UNIT_CNT];
  bit live_unit [UNIT_CNT];
  int live_ord [UNIT_CNT];
  int live_offsets [$];

  heap_op_t pending_ops [$];
  logic [STATUS_W-1:0] status_due [$];

  int idle_pct;
  int stall_pct;
  int phase;
  int accepted;
  int mismatches;
  int hold_left;
  bit held;
  int status_seen [4];

  buddy_block_allocator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // allocate in the shadow heap; offset returns the data offset on success
  function automatic logic [STATUS_W-1:0] heap_alloc(int req, output int offset);
    int need;
    int ord;
    int k;
    int blk;
    bit found;
    offset = 0;
    found = 0;
    blk = 0;
    if (req > (1 << MAXO) - HDR) return ST_TOOBIG;
    need = req + HDR;
    ord = MINO;
    while (ord < MAXO && (1 << ord) < need) ord++;
    for (k = ord; k <= MAXO && !found; k++) begin
      for (int i = 0; i < (HEAP >> k); i++) begin
        if (free_map[k][i]) begin
          blk = i << k;
          found = 1;
          break;
        end
      end
    end
    if (!found) return ST_NOMEM;
    k--;
    free_map[k][blk >> k] = 0;
    while (k > ord) begin
      k--;
      free_map[k][(blk + (1 << k)) >> k] = 1;
    end
    live_unit[blk >> MINO] = 1;
    live_ord[blk >> MINO] = ord;
    offset = blk + HDR;
    return ST_OK;
  endfunction

  // release a block and merge with free buddies
  function automatic logic [STATUS_W-1:0] heap_free(int data);
    int head;
    int ord;
    int buddy;
    if (data < HDR) return ST_UNKNOWN;
    head = data - HDR;
    if ((head & ((1 << MINO) - 1)) != 0 || head >= HEAP) return ST_UNKNOWN;
    if (!live_unit[head >> MINO]) return ST_UNKNOWN;
    live_unit[head >> MINO] = 0;
    ord = live_ord[head >> MINO];
    while (ord < MAXO) begin
      buddy = head ^ (1 << ord);
      if (!free_map[ord][buddy >> ord]) break;
      free_map[ord][buddy >> ord] = 0;
      head &= ~(1 << ord);
      ord++;
    end
    free_map[ord][head >> ord] = 1;
    return ST_OK;
  endfunction

  task automatic queue_alloc(int req);
    heap_op_t op;
    int offset;
    op.action = ACT_ALLOC;
    op.req = req[15:0];
    op.addr = 16'($urandom());
    op.status = heap_alloc(req, offset);
    if (op.status == ST_OK) live_offsets.push_back(offset);
    pending_ops.push_back(op);
  endtask

  task automatic queue_free(int data);
    heap_op_t op;
    int idx [$];
    op.action = ACT_FREE;
    op.req = 16'($urandom());
    op.addr = data[15:0];
    op.status = heap_free(data);
    idx = live_offsets.find_first_index(x) with (x == data);
    if (idx.size() > 0) live_offsets.delete(idx[0]);
    pending_ops.push_back(op);
  endtask

  // random request size: mostly small, a few large, rare oversized
  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(200);
    if (r < 85) return $urandom_range(4000);
    if (r < 95) return $urandom_range(32744);
    return $urandom_range(65535);
  endfunction

  task automatic queue_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 5) queue_free($urandom_range(65535));
      else if (r < 48 && live_offsets.size() > 0)
        queue_free(live_offsets[$urandom_range(live_offsets.size() - 1)]);
      else queue_alloc(pick_size());
    end
  endtask

  // sender: present queued items, hold each until taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        status_due.push_back(pending_ops[0].status);
        void'(pending_ops.pop_front());
        accepted++;
      end
      if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= {pending_ops[0].addr, pending_ops[0].req};
        s_tuser <= pending_ops[0].action;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off early in the first phase
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      held <= 1'b0;
    end else if (!held && phase == 0 && accepted == 100) begin
      held <= 1'b1;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: status %0d", m_tdata[1:0]);
      end else begin
        if (m_tdata !== {6'b0, status_due[0]}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("status mismatch: expected %0d got 0x%02h", status_due[0], m_tdata);
        end
        status_seen[status_due[0]]++;
        void'(status_due.pop_front());
      end
    end
  end

  initial begin
    #1_000_000_000;
    $display("[buddy_block_allocator] ERROR");
    $finish;
  end

  initial begin
    int pct_idle [4] = '{0, 62, 0, 25};
    int pct_stall [4] = '{0, 0, 62, 25};
    int first_off;
    rst = 1'b1;
    phase = 0;
    idle_pct = 0;
    stall_pct = 0;
    accepted = 0;
    mismatches = 0;
    for (int k = MINO; k <= MAXO; k++)
      for (int i = 0; i < UNIT_CNT; i++) free_map[k][i] = 0;
    for (int i = 0; i < UNIT_CNT; i++) begin
      live_unit[i] = 0;
      live_ord[i] = 0;
    end
    free_map[MAXO][0] = 1;
    free_map[MAXO][1] = 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: size extremes, exhaustion, bad frees, merges
    queue_alloc(0);
    first_off = live_offsets[0];
    queue_alloc(8);
    queue_alloc(9);
    queue_alloc(32745);
    queue_alloc(65535);
    queue_alloc(32744);
    queue_alloc(32744);
    queue_free(0);
    queue_free(23);
    queue_free(25);
    queue_free(65535);
    queue_free(65512 + HDR - 32);
    queue_free(first_off);
    queue_free(first_off);
    while (live_offsets.size() > 0) queue_free(live_offsets[0]);
    queue_alloc(32744);
    queue_alloc(32744);
    queue_alloc(32744);
    queue_alloc(1000);
    while (live_offsets.size() > 0) queue_free(live_offsets[$]);

    for (int p = 0; p < 4; p++) begin
      phase = p;
      idle_pct = pct_idle[p];
      stall_pct = pct_stall[p];
      queue_random(330);
      wait (pending_ops.size() == 0 && status_due.size() == 0);
      @(posedge clk);
    end

    repeat (100) @(posedge clk);
    if (status_due.size() != 0) mismatches++;
    $display("covered %0d items over 4 traffic phases with one long output hold", accepted);
    $display("status counts: ok %0d, no memory %0d, too large %0d, unknown free %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0) begin
      $display("[buddy_block_allocator] OK");
    end else begin
      $display("[buddy_block_allocator] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/bba_seq.sv
rtl/core/buddy_block_allocator.sv
rtl/core/bba_checker.sv
tb/testbench.sv
